// ===== hw/rtl/mpva_pkg.sv =====
// shared types and constants for the mesh prism volume accumulator
`timescale 1ns / 1ps

package mpva_pkg;

  // coordinate and accumulator widths
  localparam int COORD_BITS = 16;
  localparam int ACC_BITS   = 64;
  localparam int VOL_BITS   = 64;

  // derived arithmetic widths
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int AREA_BITS = PROD_BITS + 1;
  localparam int ZSUM_BITS = COORD_BITS + 2;
  localparam int TERM_BITS = AREA_BITS + ZSUM_BITS;
  localparam int SUM_BITS  = ((ACC_BITS > TERM_BITS) ? ACC_BITS : TERM_BITS) + 1;

  // queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [AREA_BITS-1:0]  area_t;
  typedef logic signed [ZSUM_BITS-1:0]  zsum_t;
  typedef logic signed [TERM_BITS-1:0]  term_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic signed [VOL_BITS-1:0]   vol_t;
  typedef logic [PTR_BITS-1:0]          ptr_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS - 1){1'b0}}};

  // one classified triangle waiting for accumulation
  typedef struct packed {
    term_t term;
    logic  last;
  } item_t;

endpackage

// ===== hw/rtl/mesh_prism_volume_accumulator.sv =====
// top level of the mesh prism volume accumulator
`timescale 1ns / 1ps

// channel  | direction | handshake            | payload
// triangle | in        | in_valid / in_stall  | ax ay az bx by_coord bz cx cy cz last_triangle
// total    | out       | out_valid / out_stall| volume_times_six mesh_done overflowed
//
// sustains one triangle transaction per cycle while out_stall stays low, bounded
// by the saturating add of the running total in the back end
// from input to result a triangle passes three front stages, the queue and
// the output register
// rst is synchronous and clears every valid bit, the queue and the total
// an output stall fills the four-entry queue before in_stall rises

module mesh_prism_volume_accumulator (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mpva_pkg::coord_t ax,
  input  mpva_pkg::coord_t ay,
  input  mpva_pkg::coord_t az,
  input  mpva_pkg::coord_t bx,
  input  mpva_pkg::coord_t by_coord,
  input  mpva_pkg::coord_t bz,
  input  mpva_pkg::coord_t cx,
  input  mpva_pkg::coord_t cy,
  input  mpva_pkg::coord_t cz,
  input  logic             last_triangle,
  output logic             out_valid,
  input  logic             out_stall,
  output mpva_pkg::vol_t   volume_times_six,
  output logic             mesh_done,
  output logic             overflowed
);

  // front to queue
  logic            q_push, q_full;
  mpva_pkg::item_t q_push_item;
  // queue to back
  logic            q_pop, q_not_empty;
  mpva_pkg::item_t q_pop_item;

  // front: differences, the two cross products, then area times z sum
  mpva_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ax            (ax),
    .ay            (ay),
    .az            (az),
    .bx            (bx),
    .by_coord      (by_coord),
    .bz            (bz),
    .cx            (cx),
    .cy            (cy),
    .cz            (cz),
    .last_triangle (last_triangle),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_push_item)
  );

  // decouples the multiplier pipeline from output back-pressure
  mpva_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_pop_item)
  );

  // back: saturating accumulate, sticky overflow, clear after the last triangle
  mpva_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_not_empty      (q_not_empty),
    .q_item           (q_pop_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .volume_times_six (volume_times_six),
    .mesh_done        (mesh_done),
    .overflowed       (overflowed)
  );

endmodule

// ===== hw/rtl/mpva_front.sv =====
// front pipeline: edge differences, cross products and prism term
`timescale 1ns / 1ps

module mpva_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mpva_pkg::coord_t ax,
  input  mpva_pkg::coord_t ay,
  input  mpva_pkg::coord_t az,
  input  mpva_pkg::coord_t bx,
  input  mpva_pkg::coord_t by_coord,
  input  mpva_pkg::coord_t bz,
  input  mpva_pkg::coord_t cx,
  input  mpva_pkg::coord_t cy,
  input  mpva_pkg::coord_t cz,
  input  logic             last_triangle,
  input  logic             q_full,
  output logic             q_push,
  output mpva_pkg::item_t  q_item
);

  logic            advance;
  logic            s1_valid, s2_valid, s3_valid;
  mpva_pkg::diff_t s1_dbx, s1_dcy, s1_dcx, s1_dby;
  mpva_pkg::zsum_t s1_zsum, s2_zsum;
  logic            s1_last, s2_last, s3_last;
  mpva_pkg::prod_t s2_p1, s2_p2;
  mpva_pkg::area_t area;
  mpva_pkg::term_t s3_term;

  // whole pipeline moves together unless the last stage cannot drain
  assign advance  = !s3_valid || !q_full;
  assign in_stall = !advance;
  assign q_push   = s3_valid && !q_full;
  assign q_item   = '{term: s3_term, last: s3_last};

  assign area = mpva_pkg::area_t'(s2_p1) - mpva_pkg::area_t'(s2_p2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_dbx  <= mpva_pkg::diff_t'(bx) - mpva_pkg::diff_t'(ax);
      s1_dcy  <= mpva_pkg::diff_t'(cy) - mpva_pkg::diff_t'(ay);
      s1_dcx  <= mpva_pkg::diff_t'(cx) - mpva_pkg::diff_t'(ax);
      s1_dby  <= mpva_pkg::diff_t'(by_coord) - mpva_pkg::diff_t'(ay);
      s1_zsum <= mpva_pkg::zsum_t'(az) + mpva_pkg::zsum_t'(bz) + mpva_pkg::zsum_t'(cz);
      s1_last <= last_triangle;

      s2_p1   <= mpva_pkg::prod_t'(s1_dbx) * mpva_pkg::prod_t'(s1_dcy);
      s2_p2   <= mpva_pkg::prod_t'(s1_dcx) * mpva_pkg::prod_t'(s1_dby);
      s2_zsum <= s1_zsum;
      s2_last <= s1_last;

      s3_term <= mpva_pkg::term_t'(area) * mpva_pkg::term_t'(s2_zsum);
      s3_last <= s2_last;
    end
  end

endmodule

// ===== hw/rtl/mpva_queue.sv =====
// short flop queue between the front pipeline and the accumulator
`timescale 1ns / 1ps

module mpva_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mpva_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output mpva_pkg::item_t pop_item
);

  mpva_pkg::item_t entries [mpva_pkg::QUEUE_DEPTH];
  mpva_pkg::ptr_t  wr_ptr, rd_ptr;
  mpva_pkg::cnt_t  count;

  assign full      = (count == mpva_pkg::cnt_t'(mpva_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mpva_pkg::ptr_t'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mpva_pkg::ptr_t'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + mpva_pkg::cnt_t'(1);
        2'b01:   count <= count - mpva_pkg::cnt_t'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/mpva_back.sv =====
// back end: saturating running total and output register
`timescale 1ns / 1ps

module mpva_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_not_empty,
  input  mpva_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output mpva_pkg::vol_t  volume_times_six,
  output logic            mesh_done,
  output logic            overflowed
);

  mpva_pkg::acc_t total, total_next, sat_total;
  logic           overflow_seen, overflow_next, sat_hit;
  mpva_pkg::sum_t sum;

  assign q_pop = q_not_empty && (!out_valid || !out_stall);

  always_comb begin
    sum = mpva_pkg::sum_t'(total) + mpva_pkg::sum_t'(q_item.term);
    if (sum > mpva_pkg::sum_t'(mpva_pkg::ACC_MAX)) begin
      sat_total = mpva_pkg::ACC_MAX;
      sat_hit   = 1'b1;
    end else if (sum < mpva_pkg::sum_t'(mpva_pkg::ACC_MIN)) begin
      sat_total = mpva_pkg::ACC_MIN;
      sat_hit   = 1'b1;
    end else begin
      sat_total = mpva_pkg::acc_t'(sum);
      sat_hit   = 1'b0;
    end
    overflow_next = overflow_seen || sat_hit;
    // the mesh total restarts once the last triangle is reported
    total_next    = q_item.last ? '0 : sat_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total         <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else if (q_pop) begin
      total         <= total_next;
      overflow_seen <= overflow_next && !q_item.last;
      out_valid     <= 1'b1;
    end else if (!out_stall) begin
      out_valid     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      volume_times_six <= mpva_pkg::vol_t'(sat_total);
      mesh_done        <= q_item.last;
      overflowed       <= overflow_next;
    end
  end

endmodule

// ===== hw/rtl/mpva_checker.sv =====
// port-level checks for the mesh prism volume accumulator
`timescale 1ns / 1ps

module mpva_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input mpva_pkg::vol_t volume_times_six,
  input logic           mesh_done,
  input logic           overflowed
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // reset leaves the front free to take a transaction
  a_reset_ready: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(volume_times_six)
      && $stable(mesh_done) && $stable(overflowed))
    else $error("stalled result changed");

endmodule

bind mesh_prism_volume_accumulator mpva_checker u_mpva_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .volume_times_six (volume_times_six),
  .mesh_done        (mesh_done),
  .overflowed       (overflowed)
);
